// ----- hw/rtl/linked_work_queue_assert.svh -----
// Assertion macros used by the checker file of the work queue.
`ifndef LINKED_WORK_QUEUE_ASSERT_SVH
`define LINKED_WORK_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LWQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lwq_pkg.sv -----
// ----------------------------------------------------------------------------
// lwq_pkg
// Types and constants shared by the linked work queue modules.
// ----------------------------------------------------------------------------
package lwq_pkg;

  localparam int NUM_ITEMS_DEF = 64;
  localparam int ID_W          = 6;
  localparam int KIND_W        = 2;
  localparam int COUNT_W       = 7;
  localparam int IN_DATA_W     = 8;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 16;
  localparam int OUT_USER_W    = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_RUN    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  in_range;
  } op_t;

  typedef struct packed {
    logic               fired;
    logic [ID_W-1:0]    fired_id;
    logic               more_work;
    logic [COUNT_W-1:0] item_count;
  } result_t;

endpackage

// ----- hw/rtl/lwq_link_ram.sv -----
// ----------------------------------------------------------------------------
// lwq_link_ram
// One-write, one-read table with registered read data and write bypass.
// ----------------------------------------------------------------------------
module lwq_link_ram import lwq_pkg::*; #(
  parameter int DEPTH = NUM_ITEMS_DEF,
  parameter int WIDTH = $clog2(NUM_ITEMS_DEF),
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a write to the read address on the same edge is passed straight to the read side
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lwq_exec.sv -----
// ----------------------------------------------------------------------------
// lwq_exec
// Executes one queue operation: head, tail and count registers plus the
// link table updates and the result of the operation.
// ----------------------------------------------------------------------------
module lwq_exec import lwq_pkg::*; #(
  parameter int NUM_ITEMS = NUM_ITEMS_DEF,
  localparam int AW       = $clog2(NUM_ITEMS),
  localparam int CW       = $clog2(NUM_ITEMS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  op_t           op_i,
  input  logic [AW-1:0] idx_i,
  input  logic [AW-1:0] rd_next_i,
  input  logic [AW-1:0] rd_prev_i,
  input  logic          rd_queued_i,
  output logic          next_we_o,
  output logic [AW-1:0] next_waddr_o,
  output logic [AW-1:0] next_wdata_o,
  output logic          prev_we_o,
  output logic [AW-1:0] prev_waddr_o,
  output logic [AW-1:0] prev_wdata_o,
  output logic          queued_we_o,
  output logic [AW-1:0] queued_waddr_o,
  output logic          queued_wdata_o,
  output logic [AW-1:0] head_d_o,
  output result_t       res_o
);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_dec;
  logic          next_we, prev_we, queued_we;
  logic          fired;
  logic          is_head, is_tail;

  assign cnt_dec = (cnt_q != '0) ? (cnt_q - CW'(1)) : cnt_q;
  assign is_head = (idx_i == head_q);
  assign is_tail = (idx_i == tail_q);

  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    cnt_d          = cnt_q;
    fired          = 1'b0;
    next_we        = 1'b0;
    next_waddr_o   = tail_q;
    next_wdata_o   = idx_i;
    prev_we        = 1'b0;
    prev_waddr_o   = idx_i;
    prev_wdata_o   = tail_q;
    queued_we      = 1'b0;
    queued_waddr_o = idx_i;
    queued_wdata_o = 1'b0;
    case (op_i.kind)
      KIND_ADD: begin
        if (op_i.in_range && !rd_queued_i) begin
          if (cnt_q == '0) begin
            head_d = idx_i;
          end else begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end
          tail_d         = idx_i;
          queued_we      = 1'b1;
          queued_wdata_o = 1'b1;
          if (cnt_q < CW'(NUM_ITEMS)) begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (op_i.in_range && rd_queued_i) begin
          if (is_head && is_tail) begin
            head_d = '0;
            tail_d = '0;
          end else if (is_head) begin
            head_d = rd_next_i;
          end else if (is_tail) begin
            tail_d = rd_prev_i;
          end else begin
            // splice the neighbors around the removed item
            next_we      = 1'b1;
            next_waddr_o = rd_prev_i;
            next_wdata_o = rd_next_i;
            prev_we      = 1'b1;
            prev_waddr_o = rd_next_i;
            prev_wdata_o = rd_prev_i;
          end
          queued_we = 1'b1;
          cnt_d     = cnt_dec;
        end
      end
      KIND_RUN: begin
        if (cnt_q != '0) begin
          fired = 1'b1;
          if (head_q == tail_q) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            head_d = rd_next_i;
          end
          queued_we      = 1'b1;
          queued_waddr_o = head_q;
          cnt_d          = cnt_dec;
        end
      end
      default: begin
      end
    endcase
  end

  assign next_we_o   = fire_i && next_we;
  assign prev_we_o   = fire_i && prev_we;
  assign queued_we_o = fire_i && queued_we;
  assign head_d_o    = fire_i ? head_d : head_q;

  assign res_o.fired      = fired;
  assign res_o.fired_id   = fired ? ID_W'(head_q) : '0;
  assign res_o.more_work  = (cnt_d != '0);
  assign res_o.item_count = COUNT_W'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/linked_work_queue.sv -----
// ----------------------------------------------------------------------------
// linked_work_queue
// Round-robin work queue of item ids kept as a doubly linked list.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the s1 register until it executes, which holds off
// while the output register is full and not taken; its result is then registered there.
// Throughput: one item per cycle unless the output stalls; link tables are read as
// an item is taken in, written when it executes, with a bypass for back-to-back items.
// Reset: head, tail and count clear at once; a clearing pass then clears the queued
// flag of every item, and s_axis_tready stays low until that pass ends.
module linked_work_queue import lwq_pkg::*; #(
  parameter int NUM_ITEMS = NUM_ITEMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] item_id
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] fired_id, [6] more_work,
                                               // [13:7] item_count
  output logic [OUT_USER_W-1:0] m_axis_tuser   // [0] fired
);

  localparam int AW = $clog2(NUM_ITEMS);

  logic            in_accept;
  logic            fire;
  logic            out_ok;
  kind_e           in_kind;
  logic [ID_W-1:0] in_id;
  logic [AW-1:0]   in_idx;
  logic            in_range;

  logic            s1_valid_q;
  op_t             s1_op_q;
  logic [AW-1:0]   s1_idx_q;

  logic            clr_busy_q;
  logic [AW-1:0]   clr_idx_q;

  logic            out_valid_q;
  result_t         res_q;
  result_t         res;

  logic [AW-1:0]   rd_next, rd_prev;
  logic            rd_queued;
  logic            next_we, prev_we, queued_we;
  logic [AW-1:0]   next_waddr, next_wdata, prev_waddr, prev_wdata, queued_waddr;
  logic            queued_wdata;
  logic [AW-1:0]   head_d;
  logic [AW-1:0]   next_raddr;
  logic            qram_we;
  logic [AW-1:0]   qram_waddr;
  logic            qram_wdata;

  assign in_kind   = kind_e'(s_axis_tuser[KIND_W-1:0]);
  assign in_id     = s_axis_tdata[ID_W-1:0];
  assign in_idx    = AW'(in_id);
  assign in_range  = (32'(in_id) < 32'(NUM_ITEMS));

  assign out_ok        = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && out_ok;
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || out_ok);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // a run needs the successor of the head as it stands after the item ahead
  assign next_raddr = (in_kind == KIND_RUN) ? head_d : in_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q.kind     <= in_kind;
      s1_op_q.in_range <= in_range;
      s1_idx_q         <= in_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == AW'(NUM_ITEMS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
    end
  end

  assign qram_we    = clr_busy_q || queued_we;
  assign qram_waddr = clr_busy_q ? clr_idx_q : queued_waddr;
  assign qram_wdata = clr_busy_q ? 1'b0 : queued_wdata;

  lwq_link_ram #(.DEPTH(NUM_ITEMS), .WIDTH(AW)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (in_accept),
    .raddr_i (next_raddr),
    .rdata_o (rd_next)
  );

  lwq_link_ram #(.DEPTH(NUM_ITEMS), .WIDTH(AW)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (rd_prev)
  );

  lwq_link_ram #(.DEPTH(NUM_ITEMS), .WIDTH(1)) u_queued_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (qram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (rd_queued)
  );

  lwq_exec #(.NUM_ITEMS(NUM_ITEMS)) u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .op_i           (s1_op_q),
    .idx_i          (s1_idx_q),
    .rd_next_i      (rd_next),
    .rd_prev_i      (rd_prev),
    .rd_queued_i    (rd_queued),
    .next_we_o      (next_we),
    .next_waddr_o   (next_waddr),
    .next_wdata_o   (next_wdata),
    .prev_we_o      (prev_we),
    .prev_waddr_o   (prev_waddr),
    .prev_wdata_o   (prev_wdata),
    .queued_we_o    (queued_we),
    .queued_waddr_o (queued_waddr),
    .queued_wdata_o (queued_wdata),
    .head_d_o       (head_d),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.fired;
  assign m_axis_tdata  = {2'b00, res_q.item_count, res_q.more_work, res_q.fired_id};

endmodule

// ----- hw/rtl/lwq_checker.sv -----
// ----------------------------------------------------------------------------
// lwq_checker
// Port-level checks of the work queue results, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_work_queue_assert.svh"

module lwq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic       out_pop;
  logic       out_idle;
  logic       out_stall;
  logic       out_more;
  logic       more_ok;
  logic [5:0] out_id;
  logic [6:0] out_count;

  assign out_pop   = m_axis_tvalid && m_axis_tuser[0];
  assign out_idle  = m_axis_tvalid && !m_axis_tuser[0];
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_id    = m_axis_tdata[5:0];
  assign out_more  = m_axis_tdata[6];
  assign out_count = m_axis_tdata[13:7];
  assign more_ok   = (out_more == (out_count != 7'd0));

  `LWQ_ASSERT_NOW(a_more_work_count, m_axis_tvalid, more_ok, "more_work disagrees with count")
  `LWQ_ASSERT_NOW(a_idle_id_zero, out_idle, out_id == 6'd0, "fired_id set without a pop")
  `LWQ_ASSERT_NOW(a_pop_leaves_room, out_pop, out_count < 7'd64, "count after a pop too large")
  `LWQ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result not held")

endmodule

bind linked_work_queue lwq_checker u_lwq_checker (.*);
